### hdl/cbd_pkg.sv
// Shared types and constants for the chunked body deframer.
package cbd_pkg;

  localparam int MAX_LINE_BYTES_DEF = 18;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_SIZE_LF = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_DATA_CR = 3'd3;
  localparam logic [2:0] PH_DATA_LF = 3'd4;
  localparam logic [2:0] PH_IDLE    = 3'd5;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       begin_req;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } result_t;

endpackage

### hdl/chunked_body_deframer.sv
// Top level of the chunked body deframer: front end, word queues and parser.
// A word passes the front register, the middle queue, the parser and the result queue.
// One word per cycle unless stalled; the 64-bit chunk count moves only on a taken word.
// The front register, the queue between front and parser, and the result queue
// let each side stall on its own.
// Reset (rst, synchronous) empties all queues and returns the parser to the size line.
module chunked_body_deframer import cbd_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       begin_req,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind
);

  // Classified word leaving the front register.
  item_t front_item;
  logic  front_valid;
  logic  mid_full;

  // Head of the queue between front and parser.
  item_t mid_item;
  logic  mid_empty;
  logic  mid_pop;

  // Parser result going into the result queue.
  result_t back_res;
  logic    back_push;
  logic    out_full;
  result_t out_res;

  cbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_byte    (in_byte),
    .begin_req  (begin_req),
    .full       (full),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (!mid_full)
  );

  cbd_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  // The parser takes a word only when the result queue has room, so a
  // word that makes a result is never held back halfway.
  cbd_back #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (mid_item),
    .item_valid (!mid_empty),
    .item_take  (mid_pop),
    .res_room   (!out_full),
    .res_push   (back_push),
    .res        (back_res)
  );

  cbd_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .wdata (back_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_byte = out_res.data;
  assign out_kind = out_res.kind;

endmodule

### hdl/cbd_fifo.sv
// Small first-in first-out queue of register entries.
module cbd_fifo import cbd_pkg::*; #(
  parameter int W = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNT_FULL);
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : AW'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : AW'(rptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

### hdl/cbd_front.sv
// Front end: takes input bytes into a register and classifies them.
module cbd_front import cbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       begin_req,
  output logic       full,
  output item_t      item,
  output logic       item_valid,
  input  logic       item_ready
);

  item_t item_next;
  logic  take;

  // Hex digit decode, either case.
  always_comb begin
    item_next = '0;
    item_next.data = in_byte;
    item_next.begin_req = begin_req;
    item_next.is_cr = (in_byte == CH_CR);
    item_next.is_lf = (in_byte == CH_LF);
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      item_next.is_hex = 1'b1;
      item_next.hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      item_next.is_hex = 1'b1;
      item_next.hex_val = 4'(in_byte - 8'h37);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      item_next.is_hex = 1'b1;
      item_next.hex_val = 4'(in_byte - 8'h57);
    end
  end

  assign full = item_valid && !item_ready;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

endmodule

### hdl/cbd_back.sv
// Back end: framing state machine that turns classified bytes into results.
module cbd_back import cbd_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_take,
  input  logic    res_room,
  output logic    res_push,
  output result_t res
);

  localparam int DIGIT_LIM_INT = (MAX_LINE_BYTES - 2 > 16) ? 16 : MAX_LINE_BYTES - 2;
  localparam logic [4:0] DIGIT_LIMIT = 5'(DIGIT_LIM_INT);

  logic [2:0]  phase;
  logic [63:0] chunk_remaining;
  logic [4:0]  line_bytes;
  logic        last_chunk_seen;

  logic [2:0]  phase_next;
  logic [63:0] chunk_remaining_next;
  logic [4:0]  line_bytes_next;
  logic        last_chunk_seen_next;

  logic [2:0]  ph;
  logic [63:0] rem;
  logic [4:0]  lb;
  logic        last;

  assign item_take = item_valid && res_room;

  always_comb begin
    // A begin mark clears the parse state before the byte is handled.
    ph = item.begin_req ? PH_SIZE : phase;
    rem = item.begin_req ? '0 : chunk_remaining;
    lb = item.begin_req ? '0 : line_bytes;
    last = item.begin_req ? 1'b0 : last_chunk_seen;

    phase_next = ph;
    chunk_remaining_next = rem;
    line_bytes_next = lb;
    last_chunk_seen_next = last;
    res_push = 1'b0;
    res = '0;

    unique case (ph)
      PH_SIZE: begin
        if (item.is_cr) begin
          if (lb == '0) begin
            res_push = 1'b1;
          end else begin
            phase_next = PH_SIZE_LF;
          end
        end else if (!item.is_hex || lb >= DIGIT_LIMIT) begin
          res_push = 1'b1;
        end else begin
          chunk_remaining_next = {rem[59:0], item.hex_val};
          line_bytes_next = 5'(lb + 1'b1);
        end
      end
      PH_SIZE_LF: begin
        if (!item.is_lf) begin
          res_push = 1'b1;
        end else begin
          line_bytes_next = '0;
          last_chunk_seen_next = (rem == '0);
          phase_next = (rem == '0) ? PH_DATA_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        chunk_remaining_next = rem - 64'd1;
        if (rem == 64'd1) begin
          phase_next = PH_DATA_CR;
        end
        res_push = 1'b1;
        res.data = item.data;
        res.kind = KIND_DATA;
      end
      PH_DATA_CR: begin
        if (!item.is_cr) begin
          res_push = 1'b1;
        end else begin
          phase_next = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (!item.is_lf) begin
          res_push = 1'b1;
        end else begin
          phase_next = last ? PH_IDLE : PH_SIZE;
          chunk_remaining_next = '0;
          line_bytes_next = '0;
          last_chunk_seen_next = 1'b0;
          if (last) begin
            res_push = 1'b1;
            res.kind = KIND_DONE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // Every result other than payload or completion here is a framing error.
    if (res_push && ph != PH_DATA && !(ph == PH_DATA_LF && item.is_lf)) begin
      res.kind = KIND_ERROR;
      res.data = '0;
      phase_next = PH_IDLE;
      chunk_remaining_next = '0;
      line_bytes_next = '0;
      last_chunk_seen_next = 1'b0;
    end

    if (!item_take) begin
      res_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SIZE;
      chunk_remaining <= '0;
      line_bytes <= '0;
      last_chunk_seen <= 1'b0;
    end else if (item_take) begin
      phase <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      line_bytes <= line_bytes_next;
      last_chunk_seen <= last_chunk_seen_next;
    end
  end

endmodule
